@@ design/ipid_pkg.sv @@
`default_nettype none
package ipid_pkg;

  localparam int COUNT_W  = 16;
  localparam int SPEED_W  = 16;
  localparam int TARGET_W = 15;
  localparam int GAIN_W   = 16;
  localparam int DUTY_W   = 13;
  localparam int ERR_W    = 17;
  localparam int CFG_W    = 16;
  localparam int IDX_W    = 3;
  localparam int OUT_W    = 32;

  // register indexes on the configuration port
  typedef enum logic [IDX_W-1:0] {
    REG_TARGET     = 3'd0,
    REG_GAIN_P     = 3'd1,
    REG_GAIN_I     = 3'd2,
    REG_GAIN_D     = 3'd3,
    REG_DUTY_LIMIT = 3'd4,
    REG_FOLD_VALUE = 3'd5,
    REG_STALL_KICK = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [TARGET_W-1:0] target_speed;
    logic [GAIN_W-1:0]   gain_p;
    logic [GAIN_W-1:0]   gain_i;
    logic [GAIN_W-1:0]   gain_d;
    logic [DUTY_W-1:0]   duty_limit;
    logic [DUTY_W-1:0]   fold_value;
    logic [DUTY_W-1:0]   stall_kick;
  } cfg_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] last_error;
    logic signed [ERR_W-1:0] prior_error;
    logic [DUTY_W-1:0]       duty_acc;
  } loop_state_t;

  typedef struct packed {
    logic [DUTY_W-1:0]       duty;
    logic [SPEED_W-1:0]      speed;
    logic signed [ERR_W-1:0] error;
  } update_t;

endpackage
`default_nettype wire

@@ design/incremental_pid_speed_loop.sv @@
`default_nettype none
// Incremental PID speed loop: each input word is one sample tick carrying a signed encoder
// count; each output word carries the new PWM duty and the measured speed. One word is taken
// and one produced per clock cycle while the output is not stalled. The input register loads
// at the accepting edge, and the result register loads when the word advances out of it. The
// rate is set by the loop feedback path: the three gain multiplies, the sum, the duty add and
// the clamp are combinational between the input and loop state registers, so the error
// history and duty accumulator are ready for the following sample. The result register lets
// a new sample be accepted while a finished word waits on the output. The user must write
// configuration through cfg_we/cfg_index/cfg_data while the loop is idle; the block does not enforce this.
module incremental_pid_speed_loop (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output      logic                          s_tready,
  input  wire logic [ipid_pkg::COUNT_W-1:0]  s_tdata,   // [15:0] encoder_count
  output      logic                          m_tvalid,
  input  wire logic                          m_tready,
  output      logic [ipid_pkg::OUT_W-1:0]    m_tdata,   // [12:0] duty, [28:13] speed, rest zero
  input  wire logic                          cfg_we,
  input  wire logic [ipid_pkg::IDX_W-1:0]    cfg_index,
  input  wire logic [ipid_pkg::CFG_W-1:0]    cfg_data
);
  import ipid_pkg::*;

  cfg_t                       cfg;
  loop_state_t                state;
  update_t                    upd;
  logic                       in_valid;
  logic signed [COUNT_W-1:0]  in_count;
  logic                       out_valid;
  logic [DUTY_W-1:0]          out_duty;
  logic [SPEED_W-1:0]         out_speed;
  logic                       advance;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_speed <= TARGET_W'(30);
      cfg.gain_p       <= GAIN_W'(1024);
      cfg.gain_i       <= GAIN_W'(1382);
      cfg.gain_d       <= '0;
      cfg.duty_limit   <= DUTY_W'(3000);
      cfg.fold_value   <= DUTY_W'(400);
      cfg.stall_kick   <= DUTY_W'(10);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TARGET:     cfg.target_speed <= cfg_data[TARGET_W-1:0];
        REG_GAIN_P:     cfg.gain_p       <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I:     cfg.gain_i       <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D:     cfg.gain_d       <= cfg_data[GAIN_W-1:0];
        REG_DUTY_LIMIT: cfg.duty_limit   <= cfg_data[DUTY_W-1:0];
        REG_FOLD_VALUE: cfg.fold_value   <= cfg_data[DUTY_W-1:0];
        REG_STALL_KICK: cfg.stall_kick   <= cfg_data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_count <= $signed(s_tdata);
    end
  end

  ipid_update u_update (
    .count (in_count),
    .cfg   (cfg),
    .state (state),
    .upd   (upd)
  );

  // loop state moves only when a word passes into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state.prior_error <= state.last_error;
      state.last_error  <= upd.error;
      state.duty_acc    <= upd.duty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_duty  <= upd.duty;
      out_speed <= upd.speed;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(OUT_W-DUTY_W-SPEED_W)'(0), out_speed, out_duty};

endmodule
`default_nettype wire

@@ design/ipid_update.sv @@
`default_nettype none
module ipid_update (
  input  wire logic signed [ipid_pkg::COUNT_W-1:0] count,
  input  wire ipid_pkg::cfg_t                      cfg,
  input  wire ipid_pkg::loop_state_t               state,
  output ipid_pkg::update_t                        upd
);
  import ipid_pkg::*;

  localparam int SUM_W   = 36;
  localparam int FRAC_W  = 10;
  localparam int DELTA_W = SUM_W - FRAC_W;
  localparam int NEXT_W  = DELTA_W + 1;

  logic [SPEED_W-1:0]         speed;
  logic signed [ERR_W-1:0]    err;
  logic signed [ERR_W:0]      d_p;
  logic signed [ERR_W+1:0]    d_d;
  logic signed [GAIN_W:0]     gp_s;
  logic signed [GAIN_W:0]     gi_s;
  logic signed [GAIN_W:0]     gd_s;
  logic signed [SUM_W-1:0]    prod_p;
  logic signed [SUM_W-1:0]    prod_i;
  logic signed [SUM_W-1:0]    prod_d;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SUM_W-1:0]    sum_adj;
  logic signed [DELTA_W-1:0]  delta;
  logic [DUTY_W-1:0]          base;
  logic signed [NEXT_W-1:0]   next;
  logic [DUTY_W-1:0]          duty;

  // -32768 wraps to 0x8000, which reads as 32768 unsigned
  assign speed = count[COUNT_W-1] ? SPEED_W'(-count) : SPEED_W'(count);
  assign err   = $signed({2'b00, cfg.target_speed}) - $signed({1'b0, speed});

  assign d_p = (ERR_W+1)'(err) - (ERR_W+1)'(state.last_error);
  assign d_d = (ERR_W+2)'(err) - ((ERR_W+2)'(state.last_error) <<< 1)
             + (ERR_W+2)'(state.prior_error);

  assign gp_s = $signed({1'b0, cfg.gain_p});
  assign gi_s = $signed({1'b0, cfg.gain_i});
  assign gd_s = $signed({1'b0, cfg.gain_d});

  assign prod_p = SUM_W'(gp_s) * SUM_W'(d_p);
  assign prod_i = SUM_W'(gi_s) * SUM_W'(err);
  assign prod_d = SUM_W'(gd_s) * SUM_W'(d_d);
  assign sum    = prod_p + prod_i + prod_d;

  // bias negative sums so the shift truncates toward zero
  assign sum_adj = sum[SUM_W-1] ? sum + SUM_W'((1 << FRAC_W) - 1) : sum;
  assign delta   = sum_adj[SUM_W-1:FRAC_W];

  assign base = (speed == '0) ? cfg.stall_kick : state.duty_acc;
  assign next = NEXT_W'($signed({1'b0, base})) + NEXT_W'(delta);

  always_comb begin
    if (next > $signed({(NEXT_W-DUTY_W)'(0), cfg.duty_limit})) begin
      duty = cfg.fold_value;
    end else if (next[NEXT_W-1]) begin
      duty = '0;
    end else begin
      duty = next[DUTY_W-1:0];
    end
  end

  assign upd.duty  = duty;
  assign upd.speed = speed;
  assign upd.error = err;

endmodule
`default_nettype wire
